@@ hdl/crr_pkg.sv @@
`timescale 1ns / 1ps

package crr_pkg;

   localparam int COORD_BITS         = 24;
   localparam int MAX_POINTS_DEFAULT = 64;
   localparam int DENS_BITS          = 8;
   localparam int K_BITS             = 15;
   localparam int FRAC_BITS          = 16;
   localparam int U_BITS             = FRAC_BITS + 1;
   localparam int P_BITS             = COORD_BITS + 2;
   localparam int H_BITS             = COORD_BITS + 8;
   localparam int CSR_ADDR_BITS      = 2;
   localparam int CSR_DATA_BITS      = 24;
   localparam int REQ_DATA_BITS      = 64;
   localparam int RSP_DATA_BITS      = 2 * COORD_BITS;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_DENSITY = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_Y_LOWER = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_Y_UPPER = 2'd2;

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   localparam logic [1:0] RD_B = 2'd0;
   localparam logic [1:0] RD_C = 2'd1;
   localparam logic [1:0] RD_A = 2'd2;
   localparam logic [1:0] RD_D = 2'd3;

   localparam logic [1:0] STG_B = 2'd0;
   localparam logic [1:0] STG_C = 2'd1;
   localparam logic [1:0] STG_E = 2'd2;

   localparam logic [DENS_BITS-1:0]     DENSITY_RESET = 8'd100;
   localparam logic [CSR_DATA_BITS-1:0] Y_LOWER_RESET = 24'h800000;
   localparam logic [CSR_DATA_BITS-1:0] Y_UPPER_RESET = 24'h7FFFFF;

   typedef struct packed {
      logic       load;
      logic       start;
      logic       prep;
      logic       check;
      logic       div_step;
      logic       seg_sel;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       coef;
      logic       mul;
      logic       acc;
      logic       coord_y;
      logic [1:0] stage;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic bad;
      logic out_full;
   } status_type;

endpackage

@@ hdl/crr_ctrl.sv @@
`timescale 1ns / 1ps

module crr_ctrl #(
   parameter int MAX_POINTS = crr_pkg::MAX_POINTS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_kind,
   output logic                req_tready,
   input  logic                rsp_tready,
   input  crr_pkg::status_type status,
   output crr_pkg::cmd_type    cmd
);
   import crr_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int Q_W   = K_BITS + CNT_W + FRAC_BITS;
   localparam int C_W   = $clog2(Q_W + 1);

   typedef enum logic [3:0] {
      IDLE, PREP, CHECK, DIV, SEG, READ, COEF, MUL, ACC, OUTPUT
   } state_type;

   state_type      state_ff, state_in;
   logic [C_W-1:0] cnt_ff, cnt_in;
   logic           coord_ff, coord_in;
   logic [1:0]     stage_ff, stage_in;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      coord_in   = coord_ff;
      stage_in   = stage_ff;
      cmd        = '0;
      cmd.coord_y = coord_ff;
      cmd.stage  = stage_ff;
      cmd.rd_sel = cnt_ff[1:0];
      req_tready = 1'b0;
      unique case (state_ff)
         IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_kind == KIND_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = PREP;
               end
            end
         end
         PREP: begin
            cmd.prep = 1'b1;
            state_in = CHECK;
         end
         CHECK: begin
            cmd.check = 1'b1;
            cnt_in    = '0;
            state_in  = status.bad ? OUTPUT : DIV;
         end
         DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == C_W'(Q_W - 1)) begin
               state_in = SEG;
            end
         end
         SEG: begin
            cmd.seg_sel = 1'b1;
            cnt_in      = '0;
            state_in    = READ;
         end
         READ: begin
            cmd.rd_en = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff[1:0] == RD_D) begin
               state_in = COEF;
            end
         end
         COEF: begin
            cmd.coef = 1'b1;
            coord_in = 1'b0;
            stage_in = STG_B;
            state_in = MUL;
         end
         MUL: begin
            cmd.mul  = 1'b1;
            state_in = ACC;
         end
         ACC: begin
            cmd.acc  = 1'b1;
            state_in = MUL;
            if (stage_ff == STG_E) begin
               stage_in = STG_B;
               coord_in = 1'b1;
               if (coord_ff) begin
                  state_in = OUTPUT;
               end
            end else begin
               stage_in = stage_ff + 1'b1;
            end
         end
         OUTPUT: begin
            if (!status.out_full || rsp_tready) begin
               cmd.finish = 1'b1;
               state_in   = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         cnt_ff   <= '0;
         coord_ff <= 1'b0;
         stage_ff <= STG_B;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         coord_ff <= coord_in;
         stage_ff <= stage_in;
      end
   end

endmodule

@@ hdl/crr_datapath.sv @@
`timescale 1ns / 1ps

module crr_datapath #(
   parameter int MAX_POINTS = crr_pkg::MAX_POINTS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  crr_pkg::cmd_type                    cmd,
   output crr_pkg::status_type                 status,
   input  logic                                csr_we,
   input  logic [crr_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [crr_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic [crr_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [crr_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                rsp_tuser
);
   import crr_pkg::*;

   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int S_W    = CNT_W + 1 + DENS_BITS;
   localparam int NUM_W  = K_BITS + CNT_W;
   localparam int Q_W    = NUM_W + FRAC_BITS;
   localparam int CMP_W  = S_W + K_BITS;
   localparam int PR_W   = H_BITS + U_BITS + 1;
   localparam int W_W    = 2 * COORD_BITS;

   // settings
   logic [DENS_BITS-1:0]     dens_ff;
   logic [CSR_DATA_BITS-1:0] y_lower_ff, y_upper_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dens_ff    <= DENSITY_RESET;
         y_lower_ff <= Y_LOWER_RESET;
         y_upper_ff <= Y_UPPER_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_DENSITY: dens_ff    <= csr_wdata[DENS_BITS-1:0];
            CSR_Y_LOWER: y_lower_ff <= csr_wdata;
            CSR_Y_UPPER: y_upper_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // point store
   logic [W_W-1:0]   mem [MAX_POINTS];
   logic [CNT_W-1:0] count_ff, count_in, widx;
   logic             closed_ff, closed_in;

   always_comb begin
      widx      = closed_ff ? '0 : count_ff;
      count_in  = count_ff;
      closed_in = closed_ff;
      if (cmd.load) begin
         closed_in = req_tlast;
         if (widx < CNT_W'(MAX_POINTS)) begin
            count_in = widx + 1'b1;
         end else begin
            count_in = widx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         closed_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         closed_ff <= closed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && widx < CNT_W'(MAX_POINTS)) begin
         mem[widx[ADDR_W-1:0]] <= req_tdata[W_W-1:0];
      end
   end

   // sample count and division
   logic [K_BITS-1:0] k_ff;
   logic [S_W-1:0]    s_ff;
   logic [NUM_W-1:0]  num_ff;
   logic              bad_ff;
   logic [Q_W-1:0]    dvd_ff, quo_ff;
   logic [S_W-1:0]    rem_ff;
   logic [S_W:0]      trial;
   logic              bad_now;

   assign bad_now = (count_ff < CNT_W'(2)) || (s_ff == '0) ||
                    (CMP_W'(k_ff) > CMP_W'(s_ff));
   assign trial   = {rem_ff, dvd_ff[Q_W-1]};

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         k_ff <= req_tdata[2*COORD_BITS +: K_BITS];
      end
      if (cmd.prep) begin
         s_ff   <= (S_W'(count_ff) + S_W'(2)) * S_W'(dens_ff);
         num_ff <= NUM_W'(k_ff) * NUM_W'(count_ff - 1'b1);
      end
      if (cmd.check) begin
         bad_ff <= bad_now;
         dvd_ff <= {num_ff, {FRAC_BITS{1'b0}}};
         rem_ff <= '0;
         quo_ff <= '0;
      end
      if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[Q_W-2:0], 1'b0};
         if (trial >= {1'b0, s_ff}) begin
            rem_ff <= S_W'(trial - {1'b0, s_ff});
            quo_ff <= {quo_ff[Q_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial[S_W-1:0];
            quo_ff <= {quo_ff[Q_W-2:0], 1'b0};
         end
      end
   end

   // segment and local parameter
   logic [ADDR_W-1:0] seg_ff, rd_addr;
   logic [U_BITS-1:0] u_ff;
   logic [CNT_W-1:0]  nm2;
   logic [NUM_W-1:0]  seg_raw;

   assign nm2     = count_ff - CNT_W'(2);
   assign seg_raw = quo_ff[Q_W-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (cmd.seg_sel) begin
         if (seg_raw > NUM_W'(nm2)) begin
            seg_ff <= nm2[ADDR_W-1:0];
            u_ff   <= {1'b1, {FRAC_BITS{1'b0}}};
         end else begin
            seg_ff <= seg_raw[ADDR_W-1:0];
            u_ff   <= {1'b0, quo_ff[FRAC_BITS-1:0]};
         end
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_B:    rd_addr = seg_ff;
         RD_C:    rd_addr = seg_ff + 1'b1;
         RD_A:    rd_addr = seg_ff - 1'b1;
         default: rd_addr = seg_ff + ADDR_W'(2);
      endcase
   end

   logic [W_W-1:0] pa_ff, pb_ff, pc_ff, pd_ff;

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         case (cmd.rd_sel)
            RD_B:    pb_ff <= mem[rd_addr];
            RD_C:    pc_ff <= mem[rd_addr];
            RD_A:    pa_ff <= mem[rd_addr];
            default: pd_ff <= mem[rd_addr];
         endcase
      end
   end

   // coefficients and horner evaluation
   logic a_real, d_real;
   assign a_real = (seg_ff != '0);
   assign d_real = ((CNT_W+1)'(seg_ff) + (CNT_W+1)'(2)) < (CNT_W+1)'(count_ff);

   logic signed [H_BITS-1:0] h_ff [2];
   logic signed [H_BITS-1:0] cb_ff [2];
   logic signed [H_BITS-1:0] cc_ff [2];
   logic signed [H_BITS-1:0] ce_ff [2];
   logic signed [H_BITS-1:0] ca [2];
   logic signed [H_BITS-1:0] cbv [2];
   logic signed [H_BITS-1:0] ccv [2];
   logic signed [H_BITS-1:0] cev [2];

   for (genvar c = 0; c < 2; c++) begin : g_coef
      logic signed [P_BITS-1:0] ea, eb, ec, ed;
      logic signed [H_BITS-1:0] ha, hb, hc, hd;
      always_comb begin
         eb = P_BITS'($signed(pb_ff[c*COORD_BITS +: COORD_BITS]));
         ec = P_BITS'($signed(pc_ff[c*COORD_BITS +: COORD_BITS]));
         ea = a_real ? P_BITS'($signed(pa_ff[c*COORD_BITS +: COORD_BITS]))
                     : (eb <<< 1) - ec;
         ed = d_real ? P_BITS'($signed(pd_ff[c*COORD_BITS +: COORD_BITS]))
                     : (ec <<< 1) - eb;
         ha = H_BITS'(ea);
         hb = H_BITS'(eb);
         hc = H_BITS'(ec);
         hd = H_BITS'(ed);
         ca[c]  = -ha + 3 * hb - 3 * hc + hd;
         cbv[c] = 2 * ha - 5 * hb + 4 * hc - hd;
         ccv[c] = hc - ha;
         cev[c] = hb <<< 1;
      end
   end

   logic signed [PR_W-1:0]   prod_ff, prod_rnd;
   logic signed [H_BITS-1:0] h_sel, addend, h_acc;

   assign h_sel    = h_ff[cmd.coord_y];
   assign prod_rnd = (prod_ff + PR_W'(32768)) >>> FRAC_BITS;

   always_comb begin
      case (cmd.stage)
         STG_B:   addend = cb_ff[cmd.coord_y];
         STG_C:   addend = cc_ff[cmd.coord_y];
         default: addend = ce_ff[cmd.coord_y];
      endcase
      h_acc = prod_rnd[H_BITS-1:0] + addend;
   end

   always_ff @(posedge clock) begin
      if (cmd.coef) begin
         for (int i = 0; i < 2; i++) begin
            h_ff[i]  <= ca[i];
            cb_ff[i] <= cbv[i];
            cc_ff[i] <= ccv[i];
            ce_ff[i] <= cev[i];
         end
      end
      if (cmd.mul) begin
         prod_ff <= PR_W'(h_sel) * PR_W'($signed({1'b0, u_ff}));
      end
      if (cmd.acc) begin
         h_ff[cmd.coord_y] <= h_acc;
      end
   end

   // result
   logic signed [H_BITS-1:0] hx, hy, ylo, yhi, xmax, xmin;
   logic signed [H_BITS-1:0] xs, ys;

   assign xmax = H_BITS'({1'b0, {(COORD_BITS-1){1'b1}}});
   assign xmin = -xmax - 1;

   always_comb begin
      hx  = (h_ff[0] + 1) >>> 1;
      hy  = (h_ff[1] + 1) >>> 1;
      ylo = H_BITS'($signed(y_lower_ff));
      yhi = H_BITS'($signed(y_upper_ff));
      if (hx > xmax) begin
         xs = xmax;
      end else if (hx < xmin) begin
         xs = xmin;
      end else begin
         xs = hx;
      end
      if (hy < ylo) begin
         ys = ylo;
      end else if (!(hy < yhi)) begin
         ys = yhi;
      end else begin
         ys = hy;
      end
   end

   logic               rsp_valid_ff;
   logic [W_W-1:0]     rsp_data_ff;
   logic               rsp_bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_bad_ff  <= bad_ff;
         rsp_data_ff <= bad_ff ? '0 : {ys[COORD_BITS-1:0], xs[COORD_BITS-1:0]};
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign rsp_tuser       = rsp_bad_ff;
   assign status.bad      = bad_now;
   assign status.out_full = rsp_valid_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond store depth");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("flagged result carries data");

   a_u_bound: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.seg_sel) && u_ff[FRAC_BITS] |-> u_ff[FRAC_BITS-1:0] == '0)
      else $error("local parameter above one");

endmodule

@@ hdl/catmull_rom_resampler.sv @@
`timescale 1ns / 1ps
// load request: accepted while idle, no result
// sample request: divides, reads the segment's four points and evaluates the curve;
//   the divider yields one quotient bit per cycle
//   and the shared multiplier takes six passes; a flagged request skips to the output
// one request in flight; the next is accepted once its result sits in the output register
// synchronous reset clears the point count, the closed flag and the output valid, and restores the default settings

module catmull_rom_resampler #(
   parameter int MAX_POINTS = crr_pkg::MAX_POINTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [crr_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [crr_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // point_x, point_y, sample_index, zero pad
   input  logic [crr_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // kind
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // curve_x, curve_y
   output logic [crr_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // bad_request
   output logic                              rsp_tuser
);
   import crr_pkg::*;

   cmd_type    cmd;
   status_type status;

   crr_ctrl #(
      .MAX_POINTS(MAX_POINTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_kind  (req_tuser),
      .req_tready(req_tready),
      .rsp_tready(rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   crr_datapath #(
      .MAX_POINTS(MAX_POINTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule
